// File: design/mmma_pkg.sv
// ----------------------------------------------------------------------------
// mmma_pkg
// Shared types and constants for the dual channel min/max moving average.
// ----------------------------------------------------------------------------
package mmma_pkg;

	localparam int TEMP_W     = 16;
	localparam int CHARGE_W   = 14;
	localparam int WINDOW_DEF = 8;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_sample;
		logic [CHARGE_W-1:0]      charge_sample;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_min;
		logic signed [TEMP_W-1:0] temp_max;
		logic signed [TEMP_W-1:0] temp_avg;
		logic [CHARGE_W-1:0]      charge_min;
		logic [CHARGE_W-1:0]      charge_max;
		logic [CHARGE_W-1:0]      charge_avg;
	} stats_t;

	// pipeline control shared by both lanes
	typedef struct packed {
		logic accept;   // word taken into stage 1, state updates
		logic seed;     // first word since reset
		logic adv_s2;   // stage 1 moves into stage 2
	} mmma_ctrl_t;

endpackage

// File: design/mmma_lane.sv
// ----------------------------------------------------------------------------
// mmma_lane
// One channel: running min/max, ring store with running sum, and division
// of the sum by the window length through a reciprocal multiply.
// ----------------------------------------------------------------------------
module mmma_lane #(
	parameter int WINDOW = mmma_pkg::WINDOW_DEF,
	parameter int DW     = mmma_pkg::TEMP_W,
	parameter bit SIGNED = 1'b1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mmma_pkg::mmma_ctrl_t ctrl,
	input  logic [DW-1:0]      sample,
	output logic [DW-1:0]      min_o,
	output logic [DW-1:0]      max_o,
	output logic [DW-1:0]      avg_o
);
	import mmma_pkg::*;

	localparam int L  = $clog2(WINDOW);
	localparam int AW = L;
	localparam int SW = DW + L;
	localparam int K  = SW + L;
	localparam int PW = 2 * SW + 1;
	// ceil(2^K / WINDOW): exact quotient for every magnitude below 2^SW
	localparam logic [SW:0] MULT = (SW+1)'(((64'd1 << K) + 64'(WINDOW) - 64'd1)
		/ 64'(WINDOW));
	localparam logic [DW-1:0] FLIP = SIGNED ? (DW'(1) << (DW - 1)) : '0;

	logic [DW-1:0] mem [WINDOW];
	logic [AW-1:0] ptr_q, ptr_d;
	logic          wrap_q, wrap_d;
	logic [DW-1:0] rd_q;
	logic [DW-1:0] lo_q, hi_q;
	logic [SW-1:0] sum_q;
	logic [DW-1:0] lo_s2, hi_s2;
	logic [PW-1:0] prod_s2;
	logic          neg_s2;

	logic          ptr_last;
	logic [DW-1:0] new_lo, new_hi;
	logic [SW-1:0] ext_smp, ext_old, mag;
	logic          neg;
	logic [DW-1:0] quot;

	assign ptr_last = (ptr_q == AW'(WINDOW - 1));

	always_comb begin
		ptr_d  = ptr_q;
		wrap_d = wrap_q;
		if (ctrl.accept) begin
			ptr_d  = ptr_last ? '0 : ptr_q + AW'(1);
			wrap_d = wrap_q | ptr_last;
		end
	end

	// order compare: flip the sign bit for signed samples
	always_comb begin
		new_lo = lo_q;
		new_hi = hi_q;
		if (ctrl.seed || ((sample ^ FLIP) < (lo_q ^ FLIP)))
			new_lo = sample;
		if (ctrl.seed || ((sample ^ FLIP) > (hi_q ^ FLIP)))
			new_hi = sample;
	end

	assign ext_smp = {{L{SIGNED & sample[DW-1]}}, sample};
	assign ext_old = {{L{SIGNED & rd_q[DW-1]}}, rd_q};

	assign neg = SIGNED & sum_q[SW-1];
	assign mag = neg ? (~sum_q + SW'(1)) : sum_q;

	always_ff @(posedge clk) begin
		if (ctrl.accept)
			mem[ptr_q] <= sample;
	end

	// keep the entry at the write pointer prefetched; unwritten entries read zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			wrap_q <= 1'b0;
			rd_q   <= '0;
			sum_q  <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
		end else begin
			ptr_q  <= ptr_d;
			wrap_q <= wrap_d;
			rd_q   <= wrap_d ? mem[ptr_d] : '0;
			if (ctrl.accept) begin
				sum_q <= sum_q - ext_old + ext_smp;
				lo_q  <= new_lo;
				hi_q  <= new_hi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s2) begin
			prod_s2 <= PW'(mag) * PW'(MULT);
			neg_s2  <= neg;
			lo_s2   <= lo_q;
			hi_s2   <= hi_q;
		end
	end

	assign quot  = prod_s2[K +: DW];
	assign min_o = lo_s2;
	assign max_o = hi_s2;
	assign avg_o = neg_s2 ? (~quot + DW'(1)) : quot;

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!wrap_q |-> rd_q == '0)
		else $error("prefetch of an unwritten ring entry is not zero");

	a_wrap_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_q |=> wrap_q)
		else $error("ring fill flag cleared outside reset");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept |=> (lo_q ^ FLIP) <= (hi_q ^ FLIP))
		else $error("running minimum above running maximum");

endmodule

// File: design/mmma_merge.sv
// ----------------------------------------------------------------------------
// mmma_merge
// Output register: combines the two lanes into one stats word and holds it
// until the receiver takes it.
// ----------------------------------------------------------------------------
module mmma_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                v_s2,
	input  logic [mmma_pkg::TEMP_W-1:0]         temp_min,
	input  logic [mmma_pkg::TEMP_W-1:0]         temp_max,
	input  logic [mmma_pkg::TEMP_W-1:0]         temp_avg,
	input  logic [mmma_pkg::CHARGE_W-1:0]       charge_min,
	input  logic [mmma_pkg::CHARGE_W-1:0]       charge_max,
	input  logic [mmma_pkg::CHARGE_W-1:0]       charge_avg,
	input  logic                                stats_ready,
	output logic                                stats_valid,
	output mmma_pkg::stats_t                    stats,
	output logic                                load_ok
);
	import mmma_pkg::*;

	logic   valid_q;
	stats_t stats_q;

	assign load_ok = !valid_q || stats_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && v_s2) begin
			stats_q.temp_min   <= temp_min;
			stats_q.temp_max   <= temp_max;
			stats_q.temp_avg   <= temp_avg;
			stats_q.charge_min <= charge_min;
			stats_q.charge_max <= charge_max;
			stats_q.charge_avg <= charge_avg;
		end
	end

	assign stats_valid = valid_q;
	assign stats       = stats_q;

endmodule

// File: design/dual_channel_min_max_moving_average.sv
// ----------------------------------------------------------------------------
// dual_channel_min_max_moving_average
// Running min/max and boxcar average for a temperature and a charge channel.
//
// A word on the sample channel carries one temperature sample (signed) and
// one state-of-charge sample. Every accepted word yields exactly one word on
// the stats channel with min, max and window average for both channels.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Path: a word accepted passes the state/sum register, the reciprocal
// multiply register and the output register, and stalls can hold it.
// Throughput: one word per cycle while stats_ready does not stall, set by
// the ring read and sum update in each lane from a prefetched ring entry.
// Reset: min/max are seeded by the first word, sums are zero, and ring
// entries not yet written read as zero through a fill flag, so no clearing
// pass is needed and sample_ready is high right after reset.
// Stall: while stats_ready is low the pipeline keeps taking words into its
// empty stages; once all stages are full sample_ready drops.
// ----------------------------------------------------------------------------
module dual_channel_min_max_moving_average #(
	parameter int WINDOW = mmma_pkg::WINDOW_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  mmma_pkg::sample_t  sample,
	output logic               stats_valid,
	input  logic               stats_ready,
	output mmma_pkg::stats_t   stats
);
	import mmma_pkg::*;

	logic       v_s1_q, v_s2_q, seed_q;
	logic       load_ok, ready_s2, ready_s1;
	mmma_ctrl_t ctrl;

	logic [TEMP_W-1:0]   t_min, t_max, t_avg;
	logic [CHARGE_W-1:0] c_min, c_max, c_avg;

	assign ready_s2     = !v_s2_q || load_ok;
	assign ready_s1     = !v_s1_q || ready_s2;
	assign sample_ready = ready_s1;

	assign ctrl.accept = sample_valid && ready_s1;
	assign ctrl.seed   = seed_q;
	assign ctrl.adv_s2 = v_s1_q && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			seed_q <= 1'b1;
		end else begin
			if (ready_s1)
				v_s1_q <= sample_valid;
			if (ready_s2)
				v_s2_q <= v_s1_q;
			if (ctrl.accept)
				seed_q <= 1'b0;
		end
	end

	mmma_lane #(
		.WINDOW (WINDOW),
		.DW     (TEMP_W),
		.SIGNED (1'b1)
	) u_temp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (sample.temp_sample),
		.min_o  (t_min),
		.max_o  (t_max),
		.avg_o  (t_avg)
	);

	mmma_lane #(
		.WINDOW (WINDOW),
		.DW     (CHARGE_W),
		.SIGNED (1'b0)
	) u_charge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (sample.charge_sample),
		.min_o  (c_min),
		.max_o  (c_max),
		.avg_o  (c_avg)
	);

	mmma_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s2        (v_s2_q),
		.temp_min    (t_min),
		.temp_max    (t_max),
		.temp_avg    (t_avg),
		.charge_min  (c_min),
		.charge_max  (c_max),
		.charge_avg  (c_avg),
		.stats_ready (stats_ready),
		.stats_valid (stats_valid),
		.stats       (stats),
		.load_ok     (load_ok)
	);

	a_seed_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept |=> !seed_q)
		else $error("seed flag still set after a word was accepted");

	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2_q && !load_ok |=> v_s2_q)
		else $error("stage 2 word lost while output register was full");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q && !ready_s2 |=> v_s1_q)
		else $error("stage 1 word lost while stage 2 was blocked");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual channel min/max moving average.
//
// An initial block loads sample words into a pending queue: a short directed
// run (seeding, early averages over the cleared ring, ring wrap, field
// extremes and full-scale window sums), then random words under four
// idle/stall mixes. A clocked driver offers the words, and every accepted
// word runs through a local model of the running min/max and the boxcar sum.
// A clocked monitor compares each stats word, field by field, with the
// oldest prediction. One long output hold fills the pipeline, and the
// sender drains between phases. A watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import mmma_pkg::*;

	localparam int WINDOW      = WINDOW_DEF;
	localparam int PHASE_WORDS = 275;
	localparam int LONG_HOLD   = 400;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_TAIL  = 8;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_ready;
	sample_t sample       = '0;
	logic    stats_valid;
	logic    stats_ready  = 1'b0;
	stats_t  stats;

	sample_t pending_samples[$];
	stats_t  expected_stats[$];
	stats_t  oldest;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit long_hold_req  = 1'b0;
	int hold_cycles    = 0;
	int idle_cycles    = 0;
	int samples_sent   = 0;
	int stats_checked  = 0;
	int mismatches     = 0;

	// local copy of the block state
	int temp_ring[WINDOW];
	int charge_ring[WINDOW];
	int temp_sum       = 0;
	int charge_sum     = 0;
	int temp_lo        = 0;
	int temp_hi        = 0;
	int charge_lo      = 0;
	int charge_hi      = 0;
	bit seed_pending   = 1'b1;
	int ring_idx       = 0;

	dual_channel_min_max_moving_average #(
		.WINDOW(WINDOW)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.stats_valid (stats_valid),
		.stats_ready (stats_ready),
		.stats       (stats)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the running statistics by one sample word.
	function automatic stats_t next_stats(input sample_t s);
		int     t;
		int     c;
		stats_t r;
		t = $signed(s.temp_sample);
		c = s.charge_sample;
		if (seed_pending) begin
			seed_pending = 1'b0;
			temp_lo      = t;
			temp_hi      = t;
			charge_lo    = c;
			charge_hi    = c;
		end
		if (t < temp_lo) temp_lo = t;
		if (t > temp_hi) temp_hi = t;
		if (c < charge_lo) charge_lo = c;
		if (c > charge_hi) charge_hi = c;
		temp_sum              = temp_sum - temp_ring[ring_idx] + t;
		temp_ring[ring_idx]   = t;
		charge_sum            = charge_sum - charge_ring[ring_idx] + c;
		charge_ring[ring_idx] = c;
		ring_idx              = (ring_idx == WINDOW - 1) ? 0 : ring_idx + 1;
		// signed int division truncates toward zero
		r.temp_min   = TEMP_W'(temp_lo);
		r.temp_max   = TEMP_W'(temp_hi);
		r.temp_avg   = TEMP_W'(temp_sum / WINDOW);
		r.charge_min = CHARGE_W'(charge_lo);
		r.charge_max = CHARGE_W'(charge_hi);
		r.charge_avg = CHARGE_W'(charge_sum / WINDOW);
		return r;
	endfunction

	function automatic sample_t make_sample(input int t, input int c);
		sample_t s;
		s.temp_sample   = TEMP_W'(t);
		s.charge_sample = CHARGE_W'(c);
		return s;
	endfunction

	function automatic sample_t random_sample();
		int t;
		int c;
		case ($urandom_range(9))
			0: t = $urandom_range(1) ? -32768 : 32767;
			1, 2, 3: t = $urandom;
			default: t = int'($urandom_range(8000)) - 2000;
		endcase
		c = ($urandom_range(4) == 0) ? int'($urandom) : int'($urandom_range(10000));
		return make_sample(t, c);
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Hold the sender until every offered word has come back as stats.
	task automatic drain();
		while (pending_samples.size() != 0 || sample_valid || expected_stats.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample       <= '0;
		end else begin
			if (sample_valid && sample_ready) begin
				expected_stats.push_back(next_stats(sample));
				samples_sent++;
			end
			if (!sample_valid || sample_ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					sample_valid <= 1'b1;
					sample       <= pending_samples.pop_front();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_ready <= 1'b0;
		end else begin
			if (stats_valid && stats_ready) begin
				if (expected_stats.size() == 0) begin
					$display("%0t: stats word with none expected, got %p", $time, stats);
					mismatches++;
				end else begin
					oldest = expected_stats.pop_front();
					check_field("temp_min", oldest.temp_min, stats.temp_min);
					check_field("temp_max", oldest.temp_max, stats.temp_max);
					check_field("temp_avg", oldest.temp_avg, stats.temp_avg);
					check_field("charge_min", oldest.charge_min, stats.charge_min);
					check_field("charge_max", oldest.charge_max, stats.charge_max);
					check_field("charge_avg", oldest.charge_avg, stats.charge_avg);
					stats_checked++;
				end
			end
			// long hold lets the pipeline fill and back up the input
			if (long_hold_req && hold_cycles < LONG_HOLD) begin
				hold_cycles <= hold_cycles + 1;
				stats_ready <= 1'b0;
			end else begin
				stats_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (stats_valid && stats_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// seed, then moves of min and max with the cleared ring in the average
		pending_samples.push_back(make_sample(150, 5000));
		pending_samples.push_back(make_sample(-250, 5200));
		pending_samples.push_back(make_sample(400, 4800));
		pending_samples.push_back(make_sample(-1, 1));
		pending_samples.push_back(make_sample(1, 9999));
		pending_samples.push_back(make_sample(-32768, 10000));
		pending_samples.push_back(make_sample(32767, 16383));
		pending_samples.push_back(make_sample(-7, 8191));
		pending_samples.push_back(make_sample(7, 8192));
		// full-scale window sums, positive then negative
		repeat (WINDOW) pending_samples.push_back(make_sample(32767, 16383));
		repeat (WINDOW) pending_samples.push_back(make_sample(-32768, 0));
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					long_hold_req  = 1'b1;
				end
				1: begin
					send_idle_pct  = 64;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 64;
				end
				default: begin
					send_idle_pct  = 26;
					recv_stall_pct = 26;
				end
			endcase
			repeat (PHASE_WORDS) pending_samples.push_back(random_sample());
			drain();
		end

		repeat (DRAIN_TAIL) @(posedge clk);
		$display("Sent %0d sample words and checked %0d stats words", samples_sent,
			stats_checked);
		$display("Covered: seeding, ring wrap, full-scale sums, four idle/stall mixes, long hold");
		if (mismatches == 0 && expected_stats.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
